### rtl/core/masked_byte_signature_scanner_defines.svh
// ----------------------------------------------------------------------------
// Masked byte signature scanner: assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_SIGNATURE_SCANNER_DEFINES_SVH
`define MASKED_BYTE_SIGNATURE_SCANNER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSBS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/msbs_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte signature scanner package
// Sizes, register indexes, status codes and transfer payload types.
// ----------------------------------------------------------------------------
package msbs_pkg;

    // Longest signature and the bytes that the pattern registers can hold.
    localparam int PATTERN_MAX = 32;
    localparam int REG_BYTES   = 32;
    localparam int LEN_MAX     = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int LEN_W       = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;

    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int LENGTH_W    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COUNT_W     = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_0 = 3'd0,
        REG_PATTERN_1 = 3'd1,
        REG_PATTERN_2 = 3'd2,
        REG_PATTERN_3 = 3'd3,
        REG_MASK      = 3'd4,
        REG_LENGTH    = 3'd5,
        REG_BASE      = 3'd6
    } cfg_reg_t;

    // Scan outcome reported on the last byte of a buffer.
    typedef enum logic [1:0] {
        STATUS_NONE      = 2'd0,
        STATUS_UNIQUE    = 2'd1,
        STATUS_AMBIGUOUS = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              last;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] match_address;
    } out_item_t;

    // What the compare stage hands to the tally stage with each byte.
    typedef struct packed {
        logic              last;
        logic [ADDR_W-1:0] offset;
    } scan_stage_t;

endpackage

### rtl/core/msbs_cell.sv
// ----------------------------------------------------------------------------
// Masked byte signature scanner: window cell
// Holds one byte of the sliding window with its valid flag, hands both to the
// next cell on each accepted byte and compares its byte with the pattern byte
// that lines up with it.
// ----------------------------------------------------------------------------
module msbs_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic                        prev_valid,
    input  logic [msbs_pkg::BYTE_W-1:0] prev_byte,
    input  logic                        active,
    input  logic                        compare_en,
    input  logic [msbs_pkg::BYTE_W-1:0] pattern_byte,
    output logic                        valid,
    output logic [msbs_pkg::BYTE_W-1:0] window_byte,
    output logic                        agree
);
    import msbs_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              valid_reg;
    logic              valid_next;

    // The window moves on by one byte with each accepted transfer.
    assign byte_next  = prev_byte;
    assign valid_next = prev_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg  <= '0;
            valid_reg <= 1'b0;
        end else if (advance) begin
            byte_reg  <= byte_next;
            valid_reg <= valid_next;
        end
    end

    // A cell beyond the pattern always agrees. A cell in use needs a byte of
    // the current buffer, and that byte must equal the pattern byte unless
    // the pattern byte is a wildcard.
    assign agree = !active || (valid_reg && (!compare_en || (byte_reg == pattern_byte)));

    assign valid       = valid_reg;
    assign window_byte = byte_reg;

endmodule

### rtl/core/msbs_tally.sv
// ----------------------------------------------------------------------------
// Masked byte signature scanner: match tally and result register
// Counts matches per buffer, keeps the first match address and loads the
// result on the last byte.
// ----------------------------------------------------------------------------
`include "masked_byte_signature_scanner_defines.svh"

module msbs_tally (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s1_valid,
    input  msbs_pkg::scan_stage_t       s1_item,
    input  logic                        hit,
    input  logic [msbs_pkg::ADDR_W-1:0] base_address,
    output logic                        s1_taken,
    output logic                        m_valid,
    input  logic                        m_ready,
    output msbs_pkg::out_item_t         m_data
);
    import msbs_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [ADDR_W-1:0]  first_addr_reg;
    logic [ADDR_W-1:0]  first_next;
    logic [ADDR_W-1:0]  cand_addr;
    logic               m_valid_reg;
    out_item_t          m_data_reg;
    status_t            status_next;
    logic               out_free;

    // The result register is free when empty or being read this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign s1_taken = s1_valid && (!s1_item.last || out_free);

    // Saturating match count and first match address.
    assign cand_addr  = base_address + s1_item.offset;
    assign count_next = (hit && (count_reg != 2'd2)) ? count_reg + 2'd1 : count_reg;
    assign first_next = (hit && (count_reg == 2'd0)) ? cand_addr : first_addr_reg;

    always_comb begin
        case (count_next)
            2'd0:    status_next = STATUS_NONE;
            2'd1:    status_next = STATUS_UNIQUE;
            default: status_next = STATUS_AMBIGUOUS;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s1_taken) begin
                count_reg <= s1_item.last ? '0 : count_next;
            end
            if (s1_taken && s1_item.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s1_taken) begin
            first_addr_reg <= first_next;
            if (s1_item.last) begin
                m_data_reg.status        <= status_next;
                m_data_reg.match_address <= (count_next == 2'd1) ? first_next : '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MSBS_ASSERT_IMP(a_count_saturates, 1'b1, count_reg != 2'd3, "match count exceeded two")
    `MSBS_ASSERT_NEXT(a_count_cleared, s1_taken && s1_item.last, count_reg == '0, "count kept after last byte")
    `MSBS_ASSERT_NEXT(a_result_loaded, s1_taken && s1_item.last, m_valid_reg, "last byte gave no result")
    `MSBS_ASSERT_IMP(a_address_zero, m_valid_reg && (m_data_reg.status != STATUS_UNIQUE), m_data_reg.match_address == '0, "address set without unique match")

endmodule

### rtl/core/masked_byte_signature_scanner.sv
// The result passes from the compare stage register into the result register after its last
// byte is accepted, and is then held in the result register until it is taken.
// Throughput: one byte per cycle while s_ready is high; the row of window cells advances on each accepted byte.
// A last byte waits only while the previous result has not yet been taken.
// Reset (aresetn low, synchronous) restores the configuration registers to their
// defaults and empties the pipeline and the scan state; there is no clearing pass.
// ----------------------------------------------------------------------------
// Masked byte signature scanner
// Searches a byte stream for a signature with per-byte wildcards using a row
// of window cells, and reports none, unique or ambiguous per buffer.
// ----------------------------------------------------------------------------
module masked_byte_signature_scanner (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  msbs_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output msbs_pkg::out_item_t             m_data,
    input  logic                            cfg_wen,
    input  logic [msbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import msbs_pkg::*;

    logic [REG_BYTES*BYTE_W-1:0] pattern_reg;
    logic [REG_BYTES-1:0]        mask_reg;
    logic [LENGTH_W-1:0]         length_reg;
    logic [ADDR_W-1:0]           base_reg;

    logic [LEN_W-1:0]  len_idx;
    logic [ADDR_W-1:0] len_ext;
    logic [ADDR_W-1:0] seen_reg;
    logic [ADDR_W-1:0] seen_plus;
    logic              restart_reg;
    logic              s1_valid_reg;
    scan_stage_t       s1_reg;
    logic              s1_taken;
    logic              accept;

    logic [LEN_W-1:0]           align_shift;
    logic [LEN_MAX*BYTE_W-1:0]  rev_pattern;
    logic [LEN_MAX*BYTE_W-1:0]  aligned_pattern;
    logic [LEN_MAX-1:0]         rev_mask;
    logic [LEN_MAX-1:0]         aligned_mask;
    logic [LEN_MAX-1:0]         cell_valid;
    logic [LEN_MAX*BYTE_W-1:0]  cell_byte;
    logic [LEN_MAX-1:0]         cell_agree;
    logic                       hit;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            mask_reg    <= '1;
            length_reg  <= LENGTH_W'(1);
            base_reg    <= '0;
        end else if (cfg_wen) begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_0: pattern_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
                REG_PATTERN_1: pattern_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
                REG_PATTERN_2: pattern_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
                REG_PATTERN_3: pattern_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
                REG_MASK:      mask_reg   <= cfg_wdata[REG_BYTES-1:0];
                REG_LENGTH:    length_reg <= cfg_wdata[LENGTH_W-1:0];
                REG_BASE:      base_reg   <= cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective length: zero counts as one, anything too long is cut.
    always_comb begin
        if (length_reg == '0) begin
            len_idx = '0;
        end else if (length_reg > LENGTH_W'(LEN_MAX)) begin
            len_idx = LEN_W'(LEN_MAX - 1);
        end else begin
            len_idx = LEN_W'(length_reg - LENGTH_W'(1));
        end
    end
    assign len_ext = ADDR_W'(len_idx) + ADDR_W'(1);

    // Input handshake: the compare stage empties when the tally takes it.
    assign s_ready   = !s1_valid_reg || s1_taken;
    assign accept    = s_valid && s_ready;
    assign seen_plus = (seen_reg == '1) ? seen_reg : seen_reg + ADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            restart_reg  <= 1'b1;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                seen_reg    <= s_data.last ? '0 : seen_plus;
                restart_reg <= s_data.last;
            end
            s1_valid_reg <= accept || (s1_valid_reg && !s1_taken);
        end
    end

    // Start offset of the window that ends at this byte.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg.last   <= s_data.last;
            s1_reg.offset <= seen_plus - len_ext;
        end
    end

    // Line the pattern up with the window: the newest byte meets the last
    // pattern byte in use. The first pattern byte is always compared.
    for (genvar q = 0; q < LEN_MAX; q++) begin : g_rev
        assign rev_pattern[q*BYTE_W +: BYTE_W] = pattern_reg[(LEN_MAX-1-q)*BYTE_W +: BYTE_W];
        assign rev_mask[q] = mask_reg[LEN_MAX-1-q] | (q == LEN_MAX - 1);
    end
    assign align_shift     = LEN_W'(LEN_MAX - 1) - len_idx;
    assign aligned_pattern = rev_pattern >> (int'(align_shift) * BYTE_W);
    assign aligned_mask    = rev_mask >> align_shift;

    // Row of window cells, newest byte in cell zero; a new buffer starts
    // with only the newest cell holding a byte.
    for (genvar j = 0; j < LEN_MAX; j++) begin : g_cell
        logic              prev_valid;
        logic [BYTE_W-1:0] prev_byte;
        if (j == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign prev_byte  = s_data.code_byte;
        end else begin : g_body
            assign prev_valid = cell_valid[j-1] && !restart_reg;
            assign prev_byte  = cell_byte[(j-1)*BYTE_W +: BYTE_W];
        end
        msbs_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .advance      (accept),
            .prev_valid   (prev_valid),
            .prev_byte    (prev_byte),
            .active       (LEN_W'(j) <= len_idx),
            .compare_en   (aligned_mask[j]),
            .pattern_byte (aligned_pattern[j*BYTE_W +: BYTE_W]),
            .valid        (cell_valid[j]),
            .window_byte  (cell_byte[j*BYTE_W +: BYTE_W]),
            .agree        (cell_agree[j])
        );
    end

    // The window matches when every cell in use agrees.
    assign hit = &cell_agree;

    msbs_tally u_tally (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s1_valid     (s1_valid_reg),
        .s1_item      (s1_reg),
        .hit          (hit),
        .base_address (base_reg),
        .s1_taken     (s1_taken),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

### verif/tb_masked_byte_signature_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte signature scanner testbench
// Streams code buffers through the scanner under a sweep of signature
// settings and checks every reported verdict against a cycle-free predictor
// of the wildcard search, with random gaps on both sides and one long
// receiver hold-off that backs the scanner up.
// ----------------------------------------------------------------------------
module tb_masked_byte_signature_scanner;

    import msbs_pkg::*;

    localparam int          CLK_HALF     = 2;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          LONG_STALL   = 300;
    localparam int          SWEEP_PHASES = 11;
    localparam int          PHASE_BYTES  = 48;
    localparam int          MAX_REPORTS  = 10;
    // Index beyond the register map; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        in_item_t    item;
        int unsigned gap;
    } queued_byte_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Bytes waiting to be offered and verdicts waiting to be returned.
    queued_byte_t pending_bytes [$];
    out_item_t    verdicts_due [$];

    // Copy of the signature registers as last written.
    logic [8*REG_BYTES-1:0] sig_bytes;
    logic [31:0]            sig_mask;
    logic [LENGTH_W-1:0]    sig_len_reg;
    logic [ADDR_W-1:0]      base_addr;

    // Scan state of the predictor, newest byte at index 0.
    logic [7:0]        byte_hist [0:PATTERN_MAX-1];
    logic [31:0]       bytes_taken;
    logic [COUNT_W-1:0] hits;
    logic [ADDR_W-1:0] first_hit_addr;

    int unsigned error_count    = 0;
    int unsigned bytes_accepted = 0;
    int unsigned buffers_done   = 0;
    int unsigned results_seen   = 0;
    int unsigned none_count     = 0;
    int unsigned unique_count   = 0;
    int unsigned ambig_count    = 0;
    int unsigned settings_used  = 0;
    int unsigned cycle_count    = 0;

    // Receiver behaviour, set by the stimulus process between phases.
    bit          rx_busy       = 1'b0;
    int unsigned stall_orders  = 0;
    int unsigned stalls_served = 0;
    int unsigned stall_left    = 0;
    int unsigned rx_wait       = 0;

    masked_byte_signature_scanner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Idle cycles before a transfer; none when not busy, and at least a quarter of busy draws give none.
    function automatic int unsigned draw_gap(bit busy);
        if (!busy) return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 2);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    // Signature length in force, after the zero and oversize rules.
    function automatic int unsigned used_length();
        int unsigned n;
        n = sig_len_reg;
        if (n == 0) n = 1;
        if (n > LEN_MAX) n = LEN_MAX;
        return n;
    endfunction

    // True when the newest n bytes match the signature; byte 0 is always compared.
    function automatic bit window_hit(int unsigned n);
        for (int unsigned j = 0; j < n; j++) begin
            if ((j == 0 || sig_mask[j]) && byte_hist[n-1-j] !== sig_bytes[j*8 +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_scan();
        for (int k = 0; k < PATTERN_MAX; k++) byte_hist[k] = 8'h00;
        bytes_taken    = '0;
        hits           = '0;
        first_hit_addr = '0;
    endfunction

    // Advances the predicted scan by one byte; returns 1 with the verdict on a last byte.
    function automatic bit scan_byte(input in_item_t item, output out_item_t verdict);
        int unsigned n;
        n = used_length();
        verdict = '0;
        for (int k = PATTERN_MAX - 1; k > 0; k--) byte_hist[k] = byte_hist[k-1];
        byte_hist[0] = item.code_byte;
        if (bytes_taken != 32'hFFFF_FFFF) bytes_taken = bytes_taken + 1;
        if (bytes_taken >= n && window_hit(n)) begin
            if (hits == 0) first_hit_addr = base_addr + (bytes_taken - n);
            if (hits < 2) hits = hits + 1;
        end
        if (!item.last) return 1'b0;
        verdict.status        = status_t'(hits);
        verdict.match_address = (hits == 1) ? first_hit_addr : '0;
        clear_scan();
        return 1'b1;
    endfunction

    // Register write while the scanner is idle; the local copy follows at once.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        case (idx)
            REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
                sig_bytes[int'(idx)*64 +: 64] = value;
            REG_MASK:   sig_mask    = value[31:0];
            REG_LENGTH: sig_len_reg = value[LENGTH_W-1:0];
            REG_BASE:   base_addr   = value[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every byte has gone in and every verdict has come back.
    task automatic settle();
        while (pending_bytes.size() != 0 || s_valid || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_buffer(input logic [7:0] chunk [$], input bit busy_tx);
        queued_byte_t entry;
        foreach (chunk[i]) begin
            entry.item.code_byte = chunk[i];
            entry.item.last      = (i == chunk.size() - 1);
            entry.gap            = draw_gap(busy_tx);
            pending_bytes.push_back(entry);
        end
    endtask

    // Builds a buffer of n bytes, drawn either from the signature's own bytes
    // or from the full range, and plants whole signatures into it.
    task automatic queue_buffer(int unsigned n, int unsigned plants, bit busy_tx);
        logic [7:0]  chunk [$];
        int unsigned len;
        int unsigned at;
        bit          narrow;
        len    = used_length();
        narrow = $urandom_range(0, 1);
        for (int unsigned i = 0; i < n; i++) begin
            if (narrow) chunk.push_back(sig_bytes[$urandom_range(0, len - 1)*8 +: 8]);
            else        chunk.push_back(8'($urandom_range(0, 255)));
        end
        if (n >= len) begin
            repeat (plants) begin
                at = $urandom_range(0, n - len);
                for (int unsigned j = 0; j < len; j++)
                    if (j == 0 || sig_mask[j]) chunk[at+j] = sig_bytes[j*8 +: 8];
            end
        end
        send_buffer(chunk, busy_tx);
    endtask

    // Sender: offers the next queued byte after its gap and holds it until taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_bytes.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_bytes[0].gap != 0) begin
                pending_bytes[0].gap = pending_bytes[0].gap - 1;
                s_valid <= 1'b0;
            end else begin
                s_data  <= pending_bytes[0].item;
                s_valid <= 1'b1;
                void'(pending_bytes.pop_front());
            end
        end
    end

    // Receiver: random waits per verdict, plus a long hold-off when one is ordered.
    always @(posedge aclk) begin
        int unsigned w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (stalls_served != stall_orders) begin
            stalls_served <= stall_orders;
            stall_left    <= LONG_STALL;
            m_ready       <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (m_valid && m_ready) begin
            w = draw_gap(rx_busy);
            rx_wait <= w;
            m_ready <= (w == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predicts on each byte transfer and checks each verdict transfer.
    always @(posedge aclk) begin
        out_item_t verdict;
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                bytes_accepted++;
                if (scan_byte(s_data, verdict)) begin
                    verdicts_due.push_back(verdict);
                    buffers_done++;
                end
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (verdicts_due.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Unexpected verdict: status %0d address %08h",
                                 m_data.status, m_data.match_address);
                end else begin
                    want = verdicts_due.pop_front();
                    case (want.status)
                        STATUS_UNIQUE:    unique_count++;
                        STATUS_AMBIGUOUS: ambig_count++;
                        default:          none_count++;
                    endcase
                    if (m_data.status !== want.status ||
                        m_data.match_address !== want.match_address) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"Verdict %0d differs: expected status %0d address %08h,",
                                      " got status %0d address %08h"},
                                     results_seen, want.status, want.match_address,
                                     m_data.status, m_data.match_address);
                    end
                end
            end
        end
    end

    // Guard against a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus: directed buffers, then a sweep of signature settings.
    initial begin
        int unsigned    len;
        int unsigned    n;
        int unsigned    plants;
        int unsigned    phase_bytes;
        int unsigned    guard;
        bit             busy_tx;
        bit             pressure;
        logic [63:0]    rnd;
        logic [63:0]    words [4];
        logic [31:0]    mask_val;
        logic [31:0]    base_val;
        logic [5:0]     len_val;

        sig_bytes   = '0;
        sig_mask    = 32'hFFFF_FFFF;
        sig_len_reg = 6'd1;
        base_addr   = '0;
        clear_scan();
        settings_used = 1;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: one-byte signature 0x00 at base zero.
        send_buffer('{8'h00}, 1'b0);           // unique match at address zero
        send_buffer('{8'hFF}, 1'b0);           // no match
        send_buffer('{8'h00, 8'h00}, 1'b1);    // ambiguous
        settle();

        // Signature DE AD ?? EF; mask bit 0 clear, which must be ignored.
        write_reg(REG_PATTERN_0, 64'h0000_0000_EF00_ADDE);
        write_reg(REG_MASK, 64'h0000_0000_FFFF_FFFA);
        write_reg(REG_LENGTH, 64'd4);
        write_reg(REG_BASE, 64'h0000_0000_FFFF_FFFE);
        settings_used++;
        @(negedge aclk);
        // Match at offset three, so the address wraps past the top.
        send_buffer('{8'h01, 8'h02, 8'h03, 8'hDE, 8'hAD, 8'h77, 8'hEF}, 1'b1);
        // Shorter than the signature.
        send_buffer('{8'hDE, 8'hAD, 8'h00}, 1'b0);
        // Only the first byte differs: the first byte is compared regardless.
        send_buffer('{8'h55, 8'hAD, 8'h66, 8'hEF}, 1'b1);
        settle();

        for (int ph = 0; ph < SWEEP_PHASES; ph++) begin
            for (int w = 0; w < 4; w++) words[w] = {$urandom, $urandom};
            mask_val = $urandom;
            base_val = $urandom;
            len_val  = 6'($urandom_range(1, 12));
            pressure = 1'b0;
            case (ph)
                0: begin len_val = 6'd0;  mask_val = 32'h0;        base_val = 32'h0;        end
                1: begin len_val = 6'd32; mask_val = 32'hFFFF_FFFF;                         end
                2: begin len_val = 6'd63; base_val = 32'hFFFF_FFFF;                         end
                3: begin
                    len_val  = 6'd2;
                    mask_val = 32'h0;
                    base_val = 32'hFFFF_FFFF;
                    for (int w = 0; w < 4; w++) words[w] = '1;
                end
                4: begin len_val = 6'd1; pressure = 1'b1;                                   end
                5: begin len_val = 6'd33;                                                   end
                6: begin
                    len_val  = 6'd3;
                    mask_val = 32'hFFFF_FFFF;
                    for (int w = 0; w < 4; w++) words[w] = '0;
                end
                default: ;
            endcase

            // Upper data bits are random; the scanner keeps only the register width.
            write_reg(REG_PATTERN_0, words[0]);
            write_reg(REG_PATTERN_1, words[1]);
            write_reg(REG_PATTERN_2, words[2]);
            write_reg(REG_PATTERN_3, words[3]);
            rnd = {$urandom, $urandom};
            write_reg(REG_MASK, {rnd[63:32], mask_val});
            rnd = {$urandom, $urandom};
            write_reg(REG_LENGTH, {rnd[63:6], len_val});
            rnd = {$urandom, $urandom};
            write_reg(REG_BASE, {rnd[63:32], base_val});
            if (ph == 0 || $urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            settings_used++;

            @(negedge aclk);
            busy_tx = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_busy = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (pressure) stall_orders = stall_orders + 1;

            len         = used_length();
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                if (pressure)
                    n = $urandom_range(1, 3);
                else if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(1, len);
                else
                    n = len + $urandom_range(0, 12);
                case ($urandom_range(0, 3))
                    0:       plants = 0;
                    3:       plants = 2;
                    default: plants = 1;
                endcase
                queue_buffer(n, plants, busy_tx);
                phase_bytes += n;
            end
            settle();
        end

        // Final drain, bounded so that a lost verdict is reported here.
        while (pending_bytes.size() != 0 || s_valid) @(posedge aclk);
        guard = 0;
        while (verdicts_due.size() != 0 && guard < 2000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (verdicts_due.size() != 0) begin
            error_count += verdicts_due.size();
            $display("%0d verdicts never arrived", verdicts_due.size());
        end

        $display("Scanned %0d bytes in %0d buffers across %0d signature settings.",
                 bytes_accepted, buffers_done, settings_used);
        $display("Checked %0d verdicts: %0d none, %0d unique, %0d ambiguous; %0d errors.",
                 results_seen, none_count, unique_count, ambig_count, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
